// ----- hw/rtl/cpuex_pkg.sv -----
// Shared types and constants of the teaching CPU execute block.
package cpuex_pkg;

    // Operation classes produced by the front end
    typedef enum logic [4:0] {
        OP_HALT, OP_NOP, OP_SWI, OP_ILL, OP_CALL, OP_CALLI, OP_BR, OP_SWAP,
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_NOT, OP_AND, OP_OR, OP_XOR,
        OP_SHL, OP_SHR, OP_ST, OP_STU, OP_STI, OP_CSRR, OP_ADDI, OP_LDX,
        OP_LDP, OP_CSRW, OP_CSRO, OP_CSRL, OP_CSRP
    } op_t;

    // Classified instruction word held in the queue
    typedef struct packed {
        op_t                op;
        logic [3:0]         mode;
        logic [3:0]         ra;
        logic [3:0]         rb;
        logic [3:0]         rc;
        logic signed [11:0] disp;
    } dec_t;

    // Back end sequencer states
    typedef enum logic [3:0] {
        BE_IDLE, BE_RD0, BE_RD1, BE_RD2, BE_EXEC, BE_DIV, BE_ST0, BE_LD,
        BE_ST1, BE_FIN, BE_WB0, BE_WB1, BE_DONE
    } be_state_t;

    // Opcodes
    localparam logic [3:0] OPC_HALT  = 4'h0;
    localparam logic [3:0] OPC_SWI   = 4'h1;
    localparam logic [3:0] OPC_CALL  = 4'h2;
    localparam logic [3:0] OPC_BR    = 4'h3;
    localparam logic [3:0] OPC_SWAP  = 4'h4;
    localparam logic [3:0] OPC_ARITH = 4'h5;
    localparam logic [3:0] OPC_LOGIC = 4'h6;
    localparam logic [3:0] OPC_SHIFT = 4'h7;
    localparam logic [3:0] OPC_STORE = 4'h8;
    localparam logic [3:0] OPC_MOVE  = 4'h9;

    // Branch conditions
    localparam logic [1:0] BR_ALWAYS = 2'd0;
    localparam logic [1:0] BR_EQ     = 2'd1;
    localparam logic [1:0] BR_NE     = 2'd2;
    localparam logic [1:0] BR_GT     = 2'd3;

    // Register and CSR indexes
    localparam logic [3:0] ZERO_IDX    = 4'd0;
    localparam logic [3:0] SP_IDX      = 4'd14;
    localparam logic [3:0] PC_IDX      = 4'd15;
    localparam logic [3:0] CSR_STATUS  = 4'd0;
    localparam logic [3:0] CSR_HANDLER = 4'd1;
    localparam logic [3:0] CSR_CAUSE   = 4'd2;

    // Trap reporting
    localparam logic [1:0]  TRAP_NONE     = 2'd0;
    localparam logic [1:0]  TRAP_ILLEGAL  = 2'd1;
    localparam logic [1:0]  TRAP_SWI      = 2'd2;
    localparam logic [31:0] CAUSE_ILLEGAL = 32'd1;
    localparam logic [31:0] CAUSE_SWI     = 32'd4;
    localparam logic [31:0] STATUS_IE     = 32'h4;
    localparam logic [31:0] WORD_BYTES    = 32'd4;

endpackage

// ----- hw/rtl/cpuex_front.sv -----
// Front end: classifies incoming instruction words and queues them.
module cpuex_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [3:0]         s_opcode,
    input  logic [3:0]         s_mode,
    input  logic [3:0]         s_reg_a,
    input  logic [3:0]         s_reg_b,
    input  logic [3:0]         s_reg_c,
    input  logic signed [11:0] s_displacement,
    output logic               q_valid,
    output cpuex_pkg::dec_t    q_item,
    input  logic               q_pop
);
    import cpuex_pkg::*;

    dec_t       dec;
    dec_t       q_mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       no_operands;

    assign no_operands = (s_reg_a == 4'd0) && (s_reg_b == 4'd0) && (s_reg_c == 4'd0)
                         && (s_displacement == 12'sd0);

    // Classify the opcode and mode
    always_comb begin
        dec.mode = s_mode;
        dec.ra   = s_reg_a;
        dec.rb   = s_reg_b;
        dec.rc   = s_reg_c;
        dec.disp = s_displacement;
        dec.op   = OP_ILL;
        unique case (s_opcode)
            OPC_HALT: begin
                dec.op = no_operands ? OP_HALT : OP_NOP;
            end
            OPC_SWI: begin
                if (no_operands && s_mode == 4'd0) dec.op = OP_SWI;
            end
            OPC_CALL: begin
                if (s_mode == 4'd0) dec.op = OP_CALL;
                else if (s_mode == 4'd1) dec.op = OP_CALLI;
            end
            OPC_BR: begin
                if (!s_mode[2]) dec.op = OP_BR;
            end
            OPC_SWAP: begin
                if (s_mode == 4'd0) dec.op = OP_SWAP;
            end
            OPC_ARITH: begin
                unique case (s_mode)
                    4'd0:    dec.op = OP_ADD;
                    4'd1:    dec.op = OP_SUB;
                    4'd2:    dec.op = OP_MUL;
                    4'd3:    dec.op = OP_DIV;
                    default: dec.op = OP_ILL;
                endcase
            end
            OPC_LOGIC: begin
                unique case (s_mode)
                    4'd0:    dec.op = OP_NOT;
                    4'd1:    dec.op = OP_AND;
                    4'd2:    dec.op = OP_OR;
                    4'd3:    dec.op = OP_XOR;
                    default: dec.op = OP_ILL;
                endcase
            end
            OPC_SHIFT: begin
                unique case (s_mode)
                    4'd0:    dec.op = OP_SHL;
                    4'd1:    dec.op = OP_SHR;
                    default: dec.op = OP_ILL;
                endcase
            end
            OPC_STORE: begin
                unique case (s_mode)
                    4'd0:    dec.op = OP_ST;
                    4'd1:    dec.op = OP_STU;
                    4'd2:    dec.op = OP_STI;
                    default: dec.op = OP_ILL;
                endcase
            end
            OPC_MOVE: begin
                unique case (s_mode)
                    4'd0:    dec.op = OP_CSRR;
                    4'd1:    dec.op = OP_ADDI;
                    4'd2:    dec.op = OP_LDX;
                    4'd3:    dec.op = OP_LDP;
                    4'd4:    dec.op = OP_CSRW;
                    4'd5:    dec.op = OP_CSRO;
                    4'd6:    dec.op = OP_CSRL;
                    4'd7:    dec.op = OP_CSRP;
                    default: dec.op = OP_ILL;
                endcase
            end
            default: dec.op = OP_ILL;
        endcase
    end

    // Two-entry queue towards the back end
    assign s_ready = (count_reg != 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = q_mem_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop) count_next = count_reg + 2'd1;
        else if (!push && q_pop) count_next = count_reg - 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (push) q_mem_reg[wr_ptr_reg] <= dec;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- hw/rtl/cpuex_back.sv -----
// Back end: sequencer that reads operands, runs memory, divide and write-back steps.
module cpuex_back #(
    parameter int MEM_ADDR_BITS = 16
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    input  cpuex_pkg::dec_t q_item,
    output logic            q_pop,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [31:0]     m_next_pc,
    output logic            m_is_halted,
    output logic [1:0]      m_trap_code
);
    import cpuex_pkg::*;

    localparam longint MEM_DEPTH = 64'd1 << MEM_ADDR_BITS;

    function automatic logic [31:0] csr_read(input logic [3:0] idx, input logic [31:0] st,
                                             input logic [31:0] hd, input logic [31:0] cs);
        logic [31:0] v;
        case (idx)
            CSR_STATUS:  v = st;
            CSR_HANDLER: v = hd;
            CSR_CAUSE:   v = cs;
            default:     v = 32'd0;
        endcase
        return v;
    endfunction

    be_state_t state_reg, state_next;
    dec_t      item_reg;

    // Architectural state
    logic [31:0] rf_mem [16];
    logic [15:0] rf_vld_reg;
    logic [31:0] status_reg, handler_reg, cause_reg;
    logic        stopped_reg;
    logic [7:0]  dmem [MEM_DEPTH];

    // Register file ports
    logic [3:0]  rd0_addr, rd1_addr, rf_waddr;
    logic [31:0] rd0_raw_reg, rd1_raw_reg, rd0_q, rd1_q, rf_wdata;
    logic        rd0_vld_reg, rd1_vld_reg, rf_we;

    // Data memory port
    logic [31:0]              mem_base, mem_val, mem_byte_addr;
    logic [MEM_ADDR_BITS-1:0] dm_addr;
    logic                     dm_we;
    logic [7:0]               dm_wdata, dm_rdata_reg;
    logic [2:0]               mem_cnt_reg;
    logic [1:0]               ld_byte;

    // Operands and intermediate results
    logic [31:0] ra_reg, rb_reg, rc_reg, sp_reg, pc_reg, lv_reg, res_reg;
    logic [31:0] d_ext, sp_m4, ra_call, rb_call, sum_call, sum_abd, sum_ad, sum_bcd;
    logic        go_reg;
    logic        ld_en_reg, st1_en_reg;
    logic [31:0] st0_addr_reg, st0_val_reg, ld_addr_reg;
    logic [1:0]  trap_reg;

    // Divider
    logic [31:0] rem_reg, quo_reg;
    logic [4:0]  div_cnt_reg;
    logic [32:0] rem_sh, div_diff;

    // Execute plan
    logic        ex_st0, ex_ld, ex_st1, ex_div, ex_go;
    logic [1:0]  ex_trap;
    logic [31:0] ex_st0_addr, ex_st0_val, ex_ld_addr, ex_res;

    // Write-back plan
    logic        fn_w0_en, fn_w1_en, fn_csr_en, fn_stop;
    logic [3:0]  fn_w0_idx, fn_w1_idx, fn_csr_idx;
    logic [31:0] fn_w0_val, fn_w1_val, fn_csr_val, fn_pc;
    logic        w0_en_reg, w1_en_reg;
    logic [3:0]  w0_idx_reg, w1_idx_reg;
    logic [31:0] w0_val_reg, w1_val_reg;

    // Pending and presented result
    logic [31:0] out_pc_reg, m_pc_reg;
    logic        out_halt_reg, m_halt_reg, m_valid_reg;
    logic [1:0]  out_trap_reg, m_trap_reg;
    logic        m_load;

    assign rd0_q    = rd0_vld_reg ? rd0_raw_reg : 32'd0;
    assign rd1_q    = rd1_vld_reg ? rd1_raw_reg : 32'd0;
    assign d_ext    = {{20{item_reg.disp[11]}}, item_reg.disp};
    assign sp_m4    = sp_reg - WORD_BYTES;
    assign ra_call  = (item_reg.ra == SP_IDX) ? sp_m4 : ra_reg;
    assign rb_call  = (item_reg.rb == SP_IDX) ? sp_m4 : rb_reg;
    assign sum_call = ra_call + rb_call + d_ext;
    assign sum_abd  = ra_reg + rb_reg + d_ext;
    assign sum_ad   = ra_reg + d_ext;
    assign sum_bcd  = rb_reg + rc_reg + d_ext;
    assign rem_sh   = {rem_reg, quo_reg[31]};
    assign div_diff = rem_sh - {1'b0, rc_reg};
    assign ld_byte  = mem_cnt_reg[1:0] - 2'd1;
    assign m_load   = (state_reg == BE_DONE) && (!m_valid_reg || m_ready);

    // Plan the execute step from the operands
    always_comb begin
        ex_trap     = TRAP_NONE;
        ex_st0      = 1'b0;
        ex_ld       = 1'b0;
        ex_st1      = 1'b0;
        ex_div      = 1'b0;
        ex_st0_addr = sp_m4;
        ex_st0_val  = pc_reg;
        ex_ld_addr  = sum_abd;
        unique case (item_reg.mode[1:0])
            BR_ALWAYS: ex_go = 1'b1;
            BR_EQ:     ex_go = (rb_reg == rc_reg);
            BR_NE:     ex_go = (rb_reg != rc_reg);
            BR_GT:     ex_go = ($signed(rb_reg) > $signed(rc_reg));
            default:   ex_go = 1'b0;
        endcase
        if (!stopped_reg) begin
            unique case (item_reg.op)
                OP_SWI:   ex_trap = TRAP_SWI;
                OP_ILL:   ex_trap = TRAP_ILLEGAL;
                OP_DIV: begin
                    if (rc_reg == 32'd0) ex_trap = TRAP_ILLEGAL;
                    else ex_div = 1'b1;
                end
                OP_CALL:  ex_st0 = 1'b1;
                OP_CALLI: begin
                    ex_st0     = 1'b1;
                    ex_ld      = 1'b1;
                    ex_ld_addr = sum_call;
                end
                OP_BR: begin
                    ex_ld      = ex_go && item_reg.mode[3];
                    ex_ld_addr = sum_ad;
                end
                OP_ST: begin
                    ex_st0      = 1'b1;
                    ex_st0_addr = sum_abd;
                    ex_st0_val  = rc_reg;
                end
                OP_STU: begin
                    ex_st0      = 1'b1;
                    ex_st0_addr = sum_ad;
                    ex_st0_val  = (item_reg.rc == item_reg.ra && item_reg.ra != ZERO_IDX)
                                  ? sum_ad : rc_reg;
                end
                OP_STI: begin
                    ex_ld  = 1'b1;
                    ex_st1 = 1'b1;
                end
                OP_LDX, OP_CSRL: begin
                    ex_ld      = 1'b1;
                    ex_ld_addr = sum_bcd;
                end
                OP_LDP, OP_CSRP: begin
                    ex_ld      = 1'b1;
                    ex_ld_addr = rb_reg;
                end
                default: ;
            endcase
            if (ex_trap != TRAP_NONE) begin
                ex_st0      = 1'b1;
                ex_st1      = 1'b1;
                ex_st0_addr = sp_m4;
                ex_st0_val  = status_reg;
            end
        end
    end

    // Combinational results of the execute step
    always_comb begin
        case (item_reg.op)
            OP_ADD:  ex_res = rb_reg + rc_reg;
            OP_SUB:  ex_res = rb_reg - rc_reg;
            OP_MUL:  ex_res = rb_reg * rc_reg;
            OP_NOT:  ex_res = ~rb_reg;
            OP_AND:  ex_res = rb_reg & rc_reg;
            OP_OR:   ex_res = rb_reg | rc_reg;
            OP_XOR:  ex_res = rb_reg ^ rc_reg;
            OP_SHL:  ex_res = (rc_reg[31:5] != 27'd0) ? 32'd0 : rb_reg << rc_reg[4:0];
            OP_SHR:  ex_res = (rc_reg[31:5] != 27'd0) ? 32'd0 : rb_reg >> rc_reg[4:0];
            OP_ADDI: ex_res = rb_reg + d_ext;
            OP_CSRR: ex_res = csr_read(item_reg.rb, status_reg, handler_reg, cause_reg);
            OP_CSRW: ex_res = rb_reg;
            OP_CSRO: ex_res = csr_read(item_reg.rb, status_reg, handler_reg, cause_reg) | d_ext;
            default: ex_res = rb_reg;
        endcase
    end

    // Plan register, CSR and pc updates
    always_comb begin
        fn_w0_en   = 1'b0;
        fn_w1_en   = 1'b0;
        fn_w0_idx  = item_reg.ra;
        fn_w1_idx  = item_reg.rb;
        fn_w0_val  = res_reg;
        fn_w1_val  = res_reg;
        fn_csr_en  = 1'b0;
        fn_csr_idx = item_reg.ra;
        fn_csr_val = res_reg;
        fn_stop    = 1'b0;
        if (!stopped_reg) begin
            if (trap_reg != TRAP_NONE) begin
                fn_w0_en  = 1'b1;
                fn_w0_idx = SP_IDX;
                fn_w0_val = sp_reg - (WORD_BYTES + WORD_BYTES);
                fn_w1_en  = 1'b1;
                fn_w1_idx = PC_IDX;
                fn_w1_val = handler_reg;
            end else begin
                unique case (item_reg.op)
                    OP_HALT: fn_stop = 1'b1;
                    OP_CALL, OP_CALLI: begin
                        fn_w0_en  = 1'b1;
                        fn_w0_idx = SP_IDX;
                        fn_w0_val = sp_m4;
                        fn_w1_en  = 1'b1;
                        fn_w1_idx = PC_IDX;
                        fn_w1_val = (item_reg.op == OP_CALLI) ? lv_reg : sum_call;
                    end
                    OP_BR: begin
                        fn_w0_en  = go_reg;
                        fn_w0_idx = PC_IDX;
                        fn_w0_val = item_reg.mode[3] ? lv_reg : sum_ad;
                    end
                    OP_SWAP: begin
                        fn_w0_en  = 1'b1;
                        fn_w0_idx = item_reg.rb;
                        fn_w0_val = rc_reg;
                        fn_w1_en  = 1'b1;
                        fn_w1_idx = item_reg.rc;
                        fn_w1_val = rb_reg;
                    end
                    OP_ADD, OP_SUB, OP_MUL, OP_NOT, OP_AND, OP_OR, OP_XOR, OP_SHL, OP_SHR,
                    OP_CSRR, OP_ADDI: begin
                        fn_w0_en = 1'b1;
                    end
                    OP_DIV: begin
                        fn_w0_en  = 1'b1;
                        fn_w0_val = quo_reg;
                    end
                    OP_STU: begin
                        fn_w0_en  = 1'b1;
                        fn_w0_val = sum_ad;
                    end
                    OP_LDX: begin
                        fn_w0_en  = 1'b1;
                        fn_w0_val = lv_reg;
                    end
                    OP_LDP: begin
                        fn_w0_en  = 1'b1;
                        fn_w0_val = lv_reg;
                        fn_w1_en  = 1'b1;
                        fn_w1_val = ((item_reg.ra == item_reg.rb && item_reg.ra != ZERO_IDX)
                                     ? lv_reg : rb_reg) + d_ext;
                    end
                    OP_CSRW, OP_CSRO: fn_csr_en = 1'b1;
                    OP_CSRL: begin
                        fn_csr_en  = 1'b1;
                        fn_csr_val = lv_reg;
                    end
                    OP_CSRP: begin
                        fn_csr_en  = 1'b1;
                        fn_csr_val = lv_reg;
                        fn_w0_en   = 1'b1;
                        fn_w0_idx  = item_reg.rb;
                        fn_w0_val  = rb_reg + d_ext;
                    end
                    default: ;
                endcase
            end
        end
        // r0 is never written
        fn_w0_en = fn_w0_en && (fn_w0_idx != ZERO_IDX);
        fn_w1_en = fn_w1_en && (fn_w1_idx != ZERO_IDX);
        fn_pc    = pc_reg;
        if (fn_w0_en && fn_w0_idx == PC_IDX) fn_pc = fn_w0_val;
        if (fn_w1_en && fn_w1_idx == PC_IDX) fn_pc = fn_w1_val;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BE_IDLE: if (q_valid) state_next = BE_RD0;
            BE_RD0:  state_next = BE_RD1;
            BE_RD1:  state_next = BE_RD2;
            BE_RD2:  state_next = BE_EXEC;
            BE_EXEC: begin
                if (ex_st0) state_next = BE_ST0;
                else if (ex_ld) state_next = BE_LD;
                else if (ex_st1) state_next = BE_ST1;
                else if (ex_div) state_next = BE_DIV;
                else state_next = BE_FIN;
            end
            BE_DIV:  if (div_cnt_reg == 5'd31) state_next = BE_FIN;
            BE_ST0: begin
                if (mem_cnt_reg == 3'd3) begin
                    if (ld_en_reg) state_next = BE_LD;
                    else if (st1_en_reg) state_next = BE_ST1;
                    else state_next = BE_FIN;
                end
            end
            BE_LD: begin
                if (mem_cnt_reg == 3'd4) state_next = st1_en_reg ? BE_ST1 : BE_FIN;
            end
            BE_ST1:  if (mem_cnt_reg == 3'd3) state_next = BE_FIN;
            BE_FIN:  state_next = BE_WB0;
            BE_WB0:  state_next = BE_WB1;
            BE_WB1:  state_next = BE_DONE;
            BE_DONE: if (m_load) state_next = BE_IDLE;
            default: state_next = BE_IDLE;
        endcase
    end

    // Port controls per state
    always_comb begin
        q_pop    = (state_reg == BE_IDLE) && q_valid;
        rd0_addr = item_reg.rb;
        rd1_addr = item_reg.rc;
        rf_we    = 1'b0;
        rf_waddr = w0_idx_reg;
        rf_wdata = w0_val_reg;
        mem_base = ld_addr_reg;
        mem_val  = st0_val_reg;
        dm_we    = 1'b0;
        unique case (state_reg)
            BE_IDLE: begin
                rd0_addr = q_item.rb;
                rd1_addr = q_item.rc;
            end
            BE_RD0: begin
                rd0_addr = item_reg.ra;
                rd1_addr = PC_IDX;
            end
            BE_RD1: rd0_addr = SP_IDX;
            BE_ST0: begin
                mem_base = st0_addr_reg;
                dm_we    = 1'b1;
            end
            BE_ST1: begin
                mem_base = (trap_reg != TRAP_NONE) ? sp_reg - (WORD_BYTES + WORD_BYTES)
                                                   : lv_reg;
                mem_val  = (trap_reg != TRAP_NONE) ? pc_reg : rc_reg;
                dm_we    = 1'b1;
            end
            BE_WB0: rf_we = w0_en_reg;
            BE_WB1: begin
                rf_we    = w1_en_reg;
                rf_waddr = w1_idx_reg;
                rf_wdata = w1_val_reg;
            end
            default: ;
        endcase
        mem_byte_addr = mem_base + {29'd0, mem_cnt_reg};
        dm_addr       = mem_byte_addr[MEM_ADDR_BITS-1:0];
        dm_wdata      = mem_val[{mem_cnt_reg[1:0], 3'b000} +: 8];
    end

    // Register file storage
    always_ff @(posedge aclk) begin
        if (rf_we) rf_mem[rf_waddr] <= rf_wdata;
        rd0_raw_reg <= rf_mem[rd0_addr];
        rd1_raw_reg <= rf_mem[rd1_addr];
    end

    // Data memory storage
    always_ff @(posedge aclk) begin
        if (dm_we) dmem[dm_addr] <= dm_wdata;
        dm_rdata_reg <= dmem[dm_addr];
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (state_reg != state_next) mem_cnt_reg <= 3'd0;
        else mem_cnt_reg <= mem_cnt_reg + 3'd1;
        unique case (state_reg)
            BE_IDLE: item_reg <= q_item;
            BE_RD0: begin
                rb_reg <= rd0_q;
                rc_reg <= rd1_q;
            end
            BE_RD1: begin
                ra_reg <= rd0_q;
                pc_reg <= rd1_q;
            end
            BE_RD2: sp_reg <= rd0_q;
            BE_EXEC: begin
                ld_en_reg    <= ex_ld;
                st1_en_reg   <= ex_st1;
                trap_reg     <= ex_trap;
                go_reg       <= ex_go;
                st0_addr_reg <= ex_st0_addr;
                st0_val_reg  <= ex_st0_val;
                ld_addr_reg  <= ex_ld_addr;
                res_reg      <= ex_res;
                rem_reg      <= 32'd0;
                quo_reg      <= rb_reg;
                div_cnt_reg  <= 5'd0;
            end
            BE_DIV: begin
                div_cnt_reg <= div_cnt_reg + 5'd1;
                if (!div_diff[32]) begin
                    rem_reg <= div_diff[31:0];
                    quo_reg <= {quo_reg[30:0], 1'b1};
                end else begin
                    rem_reg <= rem_sh[31:0];
                    quo_reg <= {quo_reg[30:0], 1'b0};
                end
            end
            BE_LD: begin
                if (mem_cnt_reg != 3'd0) lv_reg[{ld_byte, 3'b000} +: 8] <= dm_rdata_reg;
            end
            BE_FIN: begin
                w0_en_reg    <= fn_w0_en;
                w0_idx_reg   <= fn_w0_idx;
                w0_val_reg   <= fn_w0_val;
                w1_en_reg    <= fn_w1_en;
                w1_idx_reg   <= fn_w1_idx;
                w1_val_reg   <= fn_w1_val;
                out_pc_reg   <= fn_pc;
                out_trap_reg <= trap_reg;
                out_halt_reg <= stopped_reg || fn_stop;
            end
            default: ;
        endcase
        if (m_load) begin
            m_pc_reg   <= out_pc_reg;
            m_halt_reg <= out_halt_reg;
            m_trap_reg <= out_trap_reg;
        end
    end

    // Control and architectural registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BE_IDLE;
            rf_vld_reg  <= 16'd0;
            rd0_vld_reg <= 1'b0;
            rd1_vld_reg <= 1'b0;
            status_reg  <= 32'd0;
            handler_reg <= 32'd0;
            cause_reg   <= 32'd0;
            stopped_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd0_vld_reg <= rf_vld_reg[rd0_addr];
            rd1_vld_reg <= rf_vld_reg[rd1_addr];
            if (rf_we) rf_vld_reg[rf_waddr] <= 1'b1;
            if (state_reg == BE_FIN) begin
                if (fn_stop) stopped_reg <= 1'b1;
                if (fn_csr_en) begin
                    case (fn_csr_idx)
                        CSR_STATUS:  status_reg  <= fn_csr_val;
                        CSR_HANDLER: handler_reg <= fn_csr_val;
                        CSR_CAUSE:   cause_reg   <= fn_csr_val;
                        default: ;
                    endcase
                end
                if (trap_reg != TRAP_NONE) begin
                    cause_reg  <= (trap_reg == TRAP_SWI) ? CAUSE_SWI : CAUSE_ILLEGAL;
                    status_reg <= status_reg & ~STATUS_IE;
                end
            end
            if (m_load) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_next_pc   = m_pc_reg;
    assign m_is_halted = m_halt_reg;
    assign m_trap_code = m_trap_reg;

endmodule

// ----- hw/rtl/teaching_cpu_instruction_execute.sv -----
// Top level of the teaching CPU execute block: front end, queue and back end.
//
//  channel  | ports                                   | direction
//  ---------+-----------------------------------------+----------
//  s_       | opcode, mode, reg_a/b/c, displacement   | in
//  m_       | next_pc, is_halted, trap_code           | out
//
// Each word runs through operand reads, execute, any memory steps and write-back
// (one byte per cycle on the single data memory port); a divide runs the
// one-bit-per-cycle divider. A trap stores two words.
// Reset (aresetn low, synchronous) clears registers, CSRs and the halt flag at once.
// The two-entry queue takes words until full while the back end or m_ side stalls.
module teaching_cpu_instruction_execute #(
    parameter int MEM_ADDR_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [3:0]         s_opcode,
    input  logic [3:0]         s_mode,
    input  logic [3:0]         s_reg_a,
    input  logic [3:0]         s_reg_b,
    input  logic [3:0]         s_reg_c,
    input  logic signed [11:0] s_displacement,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [31:0]        m_next_pc,
    output logic               m_is_halted,
    output logic [1:0]         m_trap_code
);
    import cpuex_pkg::*;

    dec_t q_item;
    logic q_valid;
    logic q_pop;

    cpuex_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_mode         (s_mode),
        .s_reg_a        (s_reg_a),
        .s_reg_b        (s_reg_b),
        .s_reg_c        (s_reg_c),
        .s_displacement (s_displacement),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop)
    );

    cpuex_back #(
        .MEM_ADDR_BITS (MEM_ADDR_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_next_pc   (m_next_pc),
        .m_is_halted (m_is_halted),
        .m_trap_code (m_trap_code)
    );

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench of the teaching CPU execute block.
`timescale 1ns / 100ps

module tb_top;
    import cpuex_pkg::*;

    // Mode codes per opcode
    localparam logic [3:0] CALL_DIR = 4'd0, CALL_IND = 4'd1;
    localparam logic [3:0] BR_MEM   = 4'd8, BR_BAD   = 4'd4;
    localparam logic [3:0] AR_ADD = 4'd0, AR_SUB = 4'd1, AR_MUL = 4'd2, AR_DIV = 4'd3;
    localparam logic [3:0] LG_NOT = 4'd0, LG_AND = 4'd1, LG_OR = 4'd2, LG_XOR = 4'd3;
    localparam logic [3:0] SH_LEFT = 4'd0, SH_RIGHT = 4'd1;
    localparam logic [3:0] ST_IDX = 4'd0, ST_UPD = 4'd1, ST_IND = 4'd2;
    localparam logic [3:0] MV_CSRR = 4'd0, MV_ADDI = 4'd1, MV_LDX = 4'd2, MV_LDP = 4'd3;
    localparam logic [3:0] MV_CSRW = 4'd4, MV_CSRO = 4'd5, MV_CSRL = 4'd6, MV_CSRP = 4'd7;
    localparam int         WATCHDOG_LIMIT = 5000;
    localparam int         RANDOM_ITEMS   = 1000;

    typedef struct {
        logic [3:0]         opc;
        logic [3:0]         md;
        logic [3:0]         a;
        logic [3:0]         b;
        logic [3:0]         c;
        logic signed [11:0] d;
    } instr_t;

    typedef struct {
        logic [31:0] pc;
        logic        halted;
        logic [1:0]  trap;
    } retire_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [3:0]         s_opcode;
    logic [3:0]         s_mode;
    logic [3:0]         s_reg_a;
    logic [3:0]         s_reg_b;
    logic [3:0]         s_reg_c;
    logic signed [11:0] s_displacement;
    logic               m_valid;
    logic               m_ready;
    logic [31:0]        m_next_pc;
    logic               m_is_halted;
    logic [1:0]         m_trap_code;

    teaching_cpu_instruction_execute i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_mode         (s_mode),
        .s_reg_a        (s_reg_a),
        .s_reg_b        (s_reg_b),
        .s_reg_c        (s_reg_c),
        .s_displacement (s_displacement),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_next_pc      (m_next_pc),
        .m_is_halted    (m_is_halted),
        .m_trap_code    (m_trap_code)
    );

    // Shadow machine state
    logic [31:0] gpr [16];
    logic [31:0] status_q, handler_q, cause_q;
    bit          stopped_q;
    bit [7:0]    ram [bit [15:0]];

    instr_t  pending_instr [$];
    retire_t expected_retire [$];
    int      words_in;
    int      words_out = 0;
    int      mismatches = 0;
    int      traps_seen = 0;
    int      halts_seen = 0;
    int      idle_cycles;
    int      hold_left;
    bit      hold_done;

    function automatic logic [31:0] gpr_rd(logic [3:0] i);
        return (i == ZERO_IDX) ? 32'd0 : gpr[i];
    endfunction

    function automatic void gpr_wr(logic [3:0] i, logic [31:0] v);
        if (i != ZERO_IDX) gpr[i] = v;
    endfunction

    function automatic logic [31:0] csr_rd(logic [3:0] i);
        case (i)
            CSR_STATUS:  return status_q;
            CSR_HANDLER: return handler_q;
            CSR_CAUSE:   return cause_q;
            default:     return 32'd0;
        endcase
    endfunction

    function automatic void csr_wr(logic [3:0] i, logic [31:0] v);
        case (i)
            CSR_STATUS:  status_q = v;
            CSR_HANDLER: handler_q = v;
            CSR_CAUSE:   cause_q = v;
            default: ;
        endcase
    endfunction

    function automatic logic [31:0] ram_rd32(logic [31:0] addr);
        logic [31:0] v;
        logic [31:0] k;
        v = 0;
        for (int i = 0; i < 4; i++) begin
            k = addr + i;
            if (ram.exists(k[15:0])) v[8*i +: 8] = ram[k[15:0]];
        end
        return v;
    endfunction

    function automatic void ram_wr32(logic [31:0] addr, logic [31:0] v);
        logic [31:0] k;
        for (int i = 0; i < 4; i++) begin
            k = addr + i;
            ram[k[15:0]] = v[8*i +: 8];
        end
    endfunction

    function automatic bit ram_known(logic [31:0] addr);
        logic [31:0] k;
        for (int i = 0; i < 4; i++) begin
            k = addr + i;
            if (!ram.exists(k[15:0])) return 0;
        end
        return 1;
    endfunction

    function automatic void push_word(logic [31:0] v);
        gpr[SP_IDX] = gpr[SP_IDX] - WORD_BYTES;
        ram_wr32(gpr[SP_IDX], v);
    endfunction

    function automatic void enter_trap(logic [31:0] why);
        push_word(status_q);
        push_word(gpr[PC_IDX]);
        cause_q = why;
        status_q = status_q & ~STATUS_IE;
        gpr[PC_IDX] = handler_q;
    endfunction

    // True when every word the instruction loads has been written before
    function automatic bit loads_defined(instr_t it);
        logic [31:0] d32, sp, va, vb;
        d32 = {{20{it.d[11]}}, it.d};
        if (stopped_q) return 1;
        case (it.opc)
            OPC_CALL: if (it.md == CALL_IND) begin
                // the return address is pushed before the pointer is formed
                sp = gpr[SP_IDX] - WORD_BYTES;
                va = (it.a == SP_IDX) ? sp : gpr_rd(it.a);
                vb = (it.b == SP_IDX) ? sp : gpr_rd(it.b);
                return ram_known(va + vb + d32);
            end
            OPC_BR: if ((it.md & BR_BAD) == 0 && (it.md & BR_MEM) != 0)
                return ram_known(gpr_rd(it.a) + d32);
            OPC_STORE: if (it.md == ST_IND)
                return ram_known(gpr_rd(it.a) + gpr_rd(it.b) + d32);
            OPC_MOVE: begin
                if (it.md == MV_LDX || it.md == MV_CSRL)
                    return ram_known(gpr_rd(it.b) + gpr_rd(it.c) + d32);
                if (it.md == MV_LDP || it.md == MV_CSRP)
                    return ram_known(gpr_rd(it.b));
            end
            default: ;
        endcase
        return 1;
    endfunction

    // Advance the shadow machine by one instruction and form its retire word
    function automatic retire_t execute_instr(instr_t it);
        logic [31:0] d32, t;
        bit          bad, go;
        logic [1:0]  trap;
        logic [1:0]  cond;
        d32  = {{20{it.d[11]}}, it.d};
        bad  = 0;
        trap = TRAP_NONE;
        if (stopped_q) return '{gpr[PC_IDX], 1'b1, TRAP_NONE};
        case (it.opc)
            OPC_HALT:
                if (it.a == 0 && it.b == 0 && it.c == 0 && d32 == 0) stopped_q = 1;
            OPC_SWI:
                if ((it.md | it.a | it.b | it.c) == 0 && d32 == 0) begin
                    enter_trap(CAUSE_SWI);
                    trap = TRAP_SWI;
                end else bad = 1;
            OPC_CALL:
                if (it.md == CALL_DIR) begin
                    push_word(gpr[PC_IDX]);
                    gpr[PC_IDX] = gpr_rd(it.a) + gpr_rd(it.b) + d32;
                end else if (it.md == CALL_IND) begin
                    push_word(gpr[PC_IDX]);
                    gpr[PC_IDX] = ram_rd32(gpr_rd(it.a) + gpr_rd(it.b) + d32);
                end else bad = 1;
            OPC_BR:
                if ((it.md & BR_BAD) != 0) bad = 1;
                else begin
                    cond = it.md[1:0];
                    case (cond)
                        BR_ALWAYS: go = 1;
                        BR_EQ:     go = gpr_rd(it.b) == gpr_rd(it.c);
                        BR_NE:     go = gpr_rd(it.b) != gpr_rd(it.c);
                        default:   go = $signed(gpr_rd(it.b)) > $signed(gpr_rd(it.c));
                    endcase
                    if (go) begin
                        t = gpr_rd(it.a) + d32;
                        gpr[PC_IDX] = ((it.md & BR_MEM) != 0) ? ram_rd32(t) : t;
                    end
                end
            OPC_SWAP:
                if (it.md == 0) begin
                    t = gpr_rd(it.b);
                    gpr_wr(it.b, gpr_rd(it.c));
                    gpr_wr(it.c, t);
                end else bad = 1;
            OPC_ARITH:
                case (it.md)
                    AR_ADD: gpr_wr(it.a, gpr_rd(it.b) + gpr_rd(it.c));
                    AR_SUB: gpr_wr(it.a, gpr_rd(it.b) - gpr_rd(it.c));
                    AR_MUL: gpr_wr(it.a, gpr_rd(it.b) * gpr_rd(it.c));
                    AR_DIV:
                        if (gpr_rd(it.c) == 0) bad = 1;
                        else gpr_wr(it.a, gpr_rd(it.b) / gpr_rd(it.c));
                    default: bad = 1;
                endcase
            OPC_LOGIC:
                case (it.md)
                    LG_NOT:  gpr_wr(it.a, ~gpr_rd(it.b));
                    LG_AND:  gpr_wr(it.a, gpr_rd(it.b) & gpr_rd(it.c));
                    LG_OR:   gpr_wr(it.a, gpr_rd(it.b) | gpr_rd(it.c));
                    LG_XOR:  gpr_wr(it.a, gpr_rd(it.b) ^ gpr_rd(it.c));
                    default: bad = 1;
                endcase
            OPC_SHIFT: begin
                t = gpr_rd(it.c);
                if (it.md == SH_LEFT)
                    gpr_wr(it.a, (t >= 32) ? 32'd0 : gpr_rd(it.b) << t);
                else if (it.md == SH_RIGHT)
                    gpr_wr(it.a, (t >= 32) ? 32'd0 : gpr_rd(it.b) >> t);
                else bad = 1;
            end
            OPC_STORE:
                case (it.md)
                    ST_IDX: ram_wr32(gpr_rd(it.a) + gpr_rd(it.b) + d32, gpr_rd(it.c));
                    ST_UPD: begin
                        t = gpr_rd(it.a) + d32;
                        gpr_wr(it.a, t);
                        ram_wr32(t, gpr_rd(it.c));
                    end
                    ST_IND: ram_wr32(ram_rd32(gpr_rd(it.a) + gpr_rd(it.b) + d32),
                                     gpr_rd(it.c));
                    default: bad = 1;
                endcase
            OPC_MOVE:
                case (it.md)
                    MV_CSRR: gpr_wr(it.a, csr_rd(it.b));
                    MV_ADDI: gpr_wr(it.a, gpr_rd(it.b) + d32);
                    MV_LDX:  gpr_wr(it.a, ram_rd32(gpr_rd(it.b) + gpr_rd(it.c) + d32));
                    MV_LDP: begin
                        gpr_wr(it.a, ram_rd32(gpr_rd(it.b)));
                        gpr_wr(it.b, gpr_rd(it.b) + d32);
                    end
                    MV_CSRW: csr_wr(it.a, gpr_rd(it.b));
                    MV_CSRO: csr_wr(it.a, csr_rd(it.b) | d32);
                    MV_CSRL: csr_wr(it.a, ram_rd32(gpr_rd(it.b) + gpr_rd(it.c) + d32));
                    MV_CSRP: begin
                        csr_wr(it.a, ram_rd32(gpr_rd(it.b)));
                        gpr_wr(it.b, gpr_rd(it.b) + d32);
                    end
                    default: bad = 1;
                endcase
            default: bad = 1;
        endcase
        if (bad) begin
            enter_trap(CAUSE_ILLEGAL);
            trap = TRAP_ILLEGAL;
        end
        return '{gpr[PC_IDX], stopped_q, trap};
    endfunction

    function automatic void queue_instr(instr_t it);
        pending_instr.push_back(it);
        expected_retire.push_back(execute_instr(it));
    endfunction

    function automatic instr_t mk(logic [3:0] opc, logic [3:0] md, logic [3:0] a,
                                  logic [3:0] b, logic [3:0] c, logic signed [11:0] d);
        return '{opc, md, a, b, c, d};
    endfunction

    // Mostly legal instruction with random operands
    function automatic instr_t random_instr();
        instr_t it;
        it = mk(4'($urandom_range(OPC_MOVE, OPC_HALT)), 4'd0, 4'($urandom), 4'($urandom),
                4'($urandom), 12'($urandom));
        case (it.opc)
            OPC_HALT:  if (it.a == 0) it.a = 1;
            OPC_SWI:   if ($urandom_range(99) < 70) it = mk(OPC_SWI, 0, 0, 0, 0, 0);
            OPC_CALL:  it.md = 4'($urandom_range(CALL_IND, CALL_DIR));
            OPC_BR:    it.md = 4'($urandom_range(3, 0))
                               | (($urandom_range(1) != 0) ? BR_MEM : 4'd0);
            OPC_SWAP:  it.md = 0;
            OPC_ARITH: it.md = 4'($urandom_range(AR_DIV, AR_ADD));
            OPC_LOGIC: it.md = 4'($urandom_range(LG_XOR, LG_NOT));
            OPC_SHIFT: it.md = 4'($urandom_range(SH_RIGHT, SH_LEFT));
            OPC_STORE: it.md = 4'($urandom_range(ST_IND, ST_IDX));
            default:   it.md = 4'($urandom_range(MV_CSRP, MV_CSRR));
        endcase
        return it;
    endfunction

    // Fill the instruction stream and its expected retire words
    initial begin
        instr_t it, st;
        int     kind;
        for (int i = 0; i < 16; i++) gpr[i] = 0;
        status_q = 0; handler_q = 0; cause_q = 0; stopped_q = 0;

        // directed: operand extremes, every opcode and the corner cases
        queue_instr(mk(OPC_MOVE, MV_ADDI, SP_IDX, 0, 0, 12'sh400));
        queue_instr(mk(OPC_MOVE, MV_ADDI, 1, 0, 0, 12'sd2047));
        queue_instr(mk(OPC_MOVE, MV_ADDI, 2, 0, 0, 12'sh800));
        queue_instr(mk(OPC_MOVE, MV_ADDI, 3, 0, 0, 12'sd40));
        queue_instr(mk(OPC_MOVE, MV_CSRW, CSR_HANDLER, 1, 0, 0));
        queue_instr(mk(OPC_ARITH, AR_ADD, 4, 1, 2, 0));
        queue_instr(mk(OPC_ARITH, AR_MUL, 5, 1, 2, 0));
        queue_instr(mk(OPC_ARITH, AR_DIV, 6, 1, ZERO_IDX, 0));
        queue_instr(mk(OPC_ARITH, AR_DIV, 6, 1, 3, 0));
        queue_instr(mk(OPC_SHIFT, SH_LEFT, 7, 1, 3, 0));
        queue_instr(mk(OPC_LOGIC, LG_NOT, ZERO_IDX, 1, 0, 0));
        queue_instr(mk(OPC_LOGIC, LG_XOR, 8, 1, 2, 0));
        queue_instr(mk(OPC_MOVE, MV_ADDI, 9, 0, 0, -12'sd2));
        queue_instr(mk(OPC_STORE, ST_IDX, 9, 0, 1, 0));
        queue_instr(mk(OPC_MOVE, MV_LDX, 10, 9, 0, 0));
        queue_instr(mk(OPC_STORE, ST_UPD, 9, 0, 3, 12'sd8));
        queue_instr(mk(OPC_MOVE, MV_LDP, 12, 9, 0, 12'sd4));
        queue_instr(mk(OPC_SWAP, 0, 0, 1, 2, 0));
        queue_instr(mk(OPC_MOVE, MV_CSRR, 11, 4'd5, 0, 0));
        queue_instr(mk(OPC_MOVE, MV_CSRO, CSR_CAUSE, CSR_STATUS, 0, 12'sd4));
        queue_instr(mk(OPC_BR, {2'b00, BR_GT}, 1, 1, 2, 12'sd4));
        queue_instr(mk(OPC_CALL, CALL_DIR, 1, 0, 0, 0));
        queue_instr(mk(OPC_SWI, 0, 0, 0, 0, 0));
        queue_instr(mk(OPC_SWI, 4'd1, 0, 0, 0, 0));
        queue_instr(mk(4'd12, 0, 0, 0, 0, 0));
        queue_instr(mk(OPC_MOVE, 4'd8, 1, 1, 1, 0));
        queue_instr(mk(OPC_HALT, 0, 1, 0, 0, 0));

        // random: store/load pairs, register reloads, legal ops and noise
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            kind = $urandom_range(99);
            if (kind < 15) begin
                st = mk(OPC_STORE, ST_IDX, 4'($urandom_range(13)), 4'($urandom_range(13)),
                        4'($urandom), 12'($urandom));
                queue_instr(st);
                it = mk(OPC_MOVE, ($urandom_range(1) != 0) ? MV_LDX : MV_CSRL,
                        4'($urandom_range(13, 1)), st.a, st.b, st.d);
                n++;
            end else if (kind < 25) begin
                it = mk(OPC_MOVE, MV_ADDI, 4'($urandom_range(13, 1)), 0, 0,
                        12'($urandom_range(63)));
            end else if (kind < 85) begin
                it = random_instr();
            end else begin
                it = mk(4'($urandom), 4'($urandom), 4'($urandom), 4'($urandom),
                        4'($urandom), 12'($urandom));
                if (it.opc == OPC_HALT && it.a == 0) it.a = 4'hF;
            end
            for (int k = 0; k < 8 && !loads_defined(it); k++) it = random_instr();
            if (!loads_defined(it)) it = mk(OPC_ARITH, AR_ADD, 5, 6, 7, 0);
            queue_instr(it);
        end

        // halt, then words that find the machine stopped
        queue_instr(mk(OPC_HALT, 0, 0, 0, 0, 0));
        queue_instr(random_instr());
        queue_instr(mk(OPC_MOVE, MV_ADDI, 1, 0, 0, 12'sd1));
    end

    // Clock and reset
    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        aresetn = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1;
    end

    // Idling phase follows progress through the stream
    function automatic bit sender_idle();
        if (words_in >= 250 && words_in < 500) return $urandom_range(99) < 82;
        if (words_in >= 750) return $urandom_range(99) < 36;
        return 0;
    endfunction

    function automatic bit receiver_stall();
        if (words_in >= 500 && words_in < 750) return $urandom_range(99) < 82;
        if (words_in >= 750) return $urandom_range(99) < 36;
        return 0;
    endfunction

    // Driver: present the next word once the current one is taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid        <= 0;
            s_opcode       <= 0;
            s_mode         <= 0;
            s_reg_a        <= 0;
            s_reg_b        <= 0;
            s_reg_c        <= 0;
            s_displacement <= 0;
            words_in       <= 0;
        end else begin
            if (s_valid && s_ready) words_in <= words_in + 1;
            if (!s_valid || s_ready) begin
                if (pending_instr.size() > 0 && !sender_idle()) begin
                    s_valid        <= 1;
                    s_opcode       <= pending_instr[0].opc;
                    s_mode         <= pending_instr[0].md;
                    s_reg_a        <= pending_instr[0].a;
                    s_reg_b        <= pending_instr[0].b;
                    s_reg_c        <= pending_instr[0].c;
                    s_displacement <= pending_instr[0].d;
                    pending_instr.pop_front();
                end else begin
                    s_valid <= 0;
                end
            end
        end
    end

    // Receiver: random stalls plus one long hold-off to back the block up
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 0;
            hold_left <= 0;
            hold_done <= 0;
        end else if (hold_left > 0) begin
            m_ready   <= 0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && words_in >= 120) begin
            m_ready   <= 0;
            hold_left <= 400;
            hold_done <= 1;
        end else begin
            m_ready <= !receiver_stall();
        end
    end

    // Monitor: check each retired word against the oldest expectation
    always @(posedge aclk) begin
        retire_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            words_out <= words_out + 1;
            if (m_trap_code != TRAP_NONE) traps_seen <= traps_seen + 1;
            if (m_is_halted) halts_seen <= halts_seen + 1;
            if (expected_retire.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected retire word: pc %h halted %b trap %0d",
                             m_next_pc, m_is_halted, m_trap_code);
                mismatches <= mismatches + 1;
            end else begin
                exp_r = expected_retire.pop_front();
                if (m_next_pc !== exp_r.pc || m_is_halted !== exp_r.halted ||
                    m_trap_code !== exp_r.trap) begin
                    if (mismatches < 10)
                        $display("retire %0d: exp pc %h h %b t %0d, got pc %h h %b t %0d",
                                 words_out, exp_r.pc, exp_r.halted, exp_r.trap,
                                 m_next_pc, m_is_halted, m_trap_code);
                    mismatches <= mismatches + 1;
                end
            end
        end
    end

    // Watchdog: give up when nothing moves on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // End of run
    initial begin
        @(posedge aresetn);
        while (pending_instr.size() > 0 || s_valid) @(posedge aclk);
        while (expected_retire.size() > 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        $display("ran %0d instructions through all opcodes, %0d traps, %0d halted retires",
                 words_in, traps_seen, halts_seen);
        $display("idle phases: none, sender, receiver, both; one long receiver hold-off");
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("status: fail");
        end
        $finish;
    end

endmodule
